// ----- hw/rtl/decimal_frame_receiver_macros.svh -----
// Assertion macros shared by the decimal frame receiver RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef DECIMAL_FRAME_RECEIVER_MACROS_SVH
`define DECIMAL_FRAME_RECEIVER_MACROS_SVH

// expr must hold at every clock edge outside reset
`define DFR_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons must hold in the cycle after ante
`define DFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dfr_pkg.sv -----
// Package for the decimal frame receiver: status codes, frame constants,
// register indexes and the result struct. No dependencies.
package dfr_pkg;

    localparam int unsigned DataW  = 8;
    localparam int unsigned NumW   = 14;
    localparam int unsigned StatW  = 3;
    localparam int unsigned CountW = 4;

    localparam logic [StatW-1:0] ST_IN_FRAME   = 3'd0;
    localparam logic [StatW-1:0] ST_START      = 3'd1;
    localparam logic [StatW-1:0] ST_START_NACK = 3'd2;
    localparam logic [StatW-1:0] ST_STRAY_NACK = 3'd3;
    localparam logic [StatW-1:0] ST_ACK        = 3'd4;
    localparam logic [StatW-1:0] ST_SEQ_ERR    = 3'd5;

    // byte positions within a frame, counted after the start byte
    localparam logic [CountW-1:0] POS_SEQ      = 4'd1;
    localparam logic [CountW-1:0] POS_CMD_LAST = 4'd5;
    localparam logic [CountW-1:0] POS_LAST     = 4'd9;

    localparam logic REG_START_BYTE = 1'b0;
    localparam logic REG_LOST_LIMIT = 1'b1;

    localparam logic [DataW-1:0] START_BYTE_RST = 8'h80;
    localparam logic [DataW-1:0] LOST_LIMIT_RST = 8'd10;

    localparam logic [DataW-1:0] ASCII_ONE  = 8'h31;
    localparam logic [DataW-1:0] ASCII_NINE = 8'h39;

    typedef struct packed {
        logic [DataW-1:0] start_byte;
        logic [DataW-1:0] lost_limit;
    } t_cfg;

    typedef struct packed {
        logic [StatW-1:0] status;
        logic [NumW-1:0]  command;
        logic [NumW-1:0]  duration;
        logic [DataW-1:0] frame_seq;
        logic [DataW-1:0] seq_skipped;
    } t_result;

endpackage

// ----- hw/rtl/dfr_regs.sv -----
// APB configuration registers of the decimal frame receiver.
// Depends on dfr_pkg.
module dfr_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output dfr_pkg::t_cfg o_cfg
);
    import dfr_pkg::*;

    logic [DataW-1:0] r_start_byte;
    logic [DataW-1:0] r_lost_limit;
    logic             wr_en;
    logic             sel;

    assign wr_en  = psel && penable && pwrite;
    assign sel    = paddr[2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_lost_limit <= LOST_LIMIT_RST;
        end else if (wr_en) begin
            unique case (sel)
                REG_START_BYTE: r_start_byte <= pwdata[DataW-1:0];
                REG_LOST_LIMIT: r_lost_limit <= pwdata[DataW-1:0];
                default:        r_start_byte <= r_start_byte;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_START_BYTE: prdata = {24'd0, r_start_byte};
            REG_LOST_LIMIT: prdata = {24'd0, r_lost_limit};
            default:        prdata = 32'd0;
        endcase
    end

    assign o_cfg.start_byte = r_start_byte;
    assign o_cfg.lost_limit = r_lost_limit;

endmodule

// ----- hw/rtl/dfr_deframe.sv -----
// Frame state and per-byte deframing logic: position count, sequence check,
// digit accumulation. Depends on dfr_pkg and the assertion macro header.
`include "decimal_frame_receiver_macros.svh"

module dfr_deframe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [dfr_pkg::DataW-1:0]     i_rx_byte,
    input  dfr_pkg::t_cfg                 i_cfg,
    output dfr_pkg::t_result              o_result
);
    import dfr_pkg::*;

    logic [CountW-1:0] r_count,    n_count;
    logic [DataW-1:0]  r_expected, n_expected;
    logic [DataW-1:0]  r_seq_hold, n_seq_hold;
    logic [NumW-1:0]   r_cmd,      n_cmd;
    logic [NumW-1:0]   r_dur,      n_dur;

    logic              hit;
    logic              pending;
    logic [3:0]        digit;
    logic [DataW-1:0]  gap;
    logic [NumW-1:0]   cmd_mac;
    logic [NumW-1:0]   dur_mac;

    assign hit     = (i_rx_byte == i_cfg.start_byte);
    assign pending = (r_count != '0);
    assign digit   = (i_rx_byte >= ASCII_ONE && i_rx_byte <= ASCII_NINE)
                   ? i_rx_byte[3:0] : 4'd0;
    assign gap     = r_seq_hold - r_expected;
    // x10 as shift-and-add, wraps at 14 bits
    assign cmd_mac = (r_cmd << 3) + (r_cmd << 1) + NumW'(digit);
    assign dur_mac = (r_dur << 3) + (r_dur << 1) + NumW'(digit);

    always_comb begin
        n_count    = r_count;
        n_expected = r_expected;
        n_seq_hold = r_seq_hold;
        n_cmd      = r_cmd;
        n_dur      = r_dur;
        o_result   = '0;
        if (hit) begin
            o_result.status = pending ? ST_START_NACK : ST_START;
            n_count    = POS_SEQ;
            n_seq_hold = '0;
            n_cmd      = '0;
            n_dur      = '0;
        end else if (pending) begin
            o_result.status = ST_IN_FRAME;
            n_count = r_count + 4'd1;
            if (r_count == POS_SEQ) begin
                n_seq_hold = i_rx_byte;
            end else if (r_count <= POS_CMD_LAST) begin
                n_cmd = cmd_mac;
            end else begin
                n_dur = dur_mac;
            end
            if (r_count >= POS_LAST) begin
                // sequence byte sits at POS_SEQ, so r_seq_hold is final here
                o_result.frame_seq   = r_seq_hold;
                o_result.seq_skipped = gap;
                if (gap < i_cfg.lost_limit) begin
                    o_result.status   = ST_ACK;
                    o_result.command  = r_cmd;
                    o_result.duration = dur_mac;
                    n_expected        = r_seq_hold + 8'd1;
                end else begin
                    o_result.status = ST_SEQ_ERR;
                end
                n_count = '0;
            end
        end else begin
            o_result.status = ST_STRAY_NACK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_expected <= '0;
            r_seq_hold <= '0;
            r_cmd      <= '0;
            r_dur      <= '0;
        end else if (i_en) begin
            r_count    <= n_count;
            r_expected <= n_expected;
            r_seq_hold <= n_seq_hold;
            r_cmd      <= n_cmd;
            r_dur      <= n_dur;
        end
    end

    `DFR_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= POS_LAST, "frame count out of range")
    `DFR_ASSERT_NEXT(a_resync, i_clk, i_rst_n, i_en && o_result.status == ST_ACK, r_expected == DataW'($past(o_result.frame_seq) + 8'd1), "expected sequence not resynced")
    `DFR_ASSERT_NEXT(a_stray_idle, i_clk, i_rst_n, i_en && !hit && !pending, r_count == '0, "stray byte opened a frame")

endmodule

// ----- hw/rtl/decimal_frame_receiver.sv -----
// Top level of the decimal frame receiver: byte handshake, result register
// and configuration port. Depends on dfr_pkg, dfr_regs, dfr_deframe.
// One byte in gives one result out. A byte is taken every clock cycle while
// the result register is empty or being drained in the same cycle; the result
// is registered and appears in the cycle after the byte is taken. Per-byte
// work (start match, x10 digit accumulate, 8-bit sequence gap compare) is one
// combinational pass from the frame state to the result register.
`include "decimal_frame_receiver_macros.svh"

module decimal_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [13:0] o_command,
    output logic [13:0] o_duration,
    output logic [7:0]  o_frame_seq,
    output logic [7:0]  o_seq_skipped,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dfr_pkg::*;

    t_cfg    cfg;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    accept;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    dfr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dfr_deframe u_deframe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (accept),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_command     = r_out.command;
    assign o_duration    = r_out.duration;
    assign o_frame_seq   = r_out.frame_seq;
    assign o_seq_skipped = r_out.seq_skipped;

    `DFR_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, accept, o_valid, "accepted item gave no result")
    `DFR_ASSERT_NEXT(a_drain, i_clk, i_rst_n, o_valid && i_ready && !i_valid, !o_valid, "result repeated")
    `DFR_ASSERT_ALWAYS(a_status_code, i_clk, i_rst_n, !o_valid || o_status <= ST_SEQ_ERR, "undefined status code")

endmodule
